// File: hw/rtl/rttk_pkg.sv
// shared constants, types and reset-score function for the ranked top-k table
package rttk_pkg;

   // default geometry
   localparam int unsigned GROUPS_DEF  = 16;
   localparam int unsigned CLASSES_DEF = 5;
   localparam int unsigned RANKS_DEF   = 5;

   // fixed field widths
   localparam int unsigned GROUP_W   = 4;
   localparam int unsigned CLASS_W   = 3;
   localparam int unsigned RRANK_W   = 3;
   localparam int unsigned PLACED_W  = 3;
   localparam int unsigned POINTS_W  = 32;
   localparam int unsigned PAYLOAD_W = 64;
   localparam int unsigned SLOT_W    = POINTS_W + PAYLOAD_W;

   // reset scores
   localparam logic [POINTS_W-1:0] TOP_POINTS  = 32'd100000;
   localparam logic [POINTS_W-1:0] STEP_POINTS = 32'd20000;

   // item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // capture request beat
      logic fetch;   // read list row
      logic eval;    // compare, build new row and result
      logic store;   // write row back if placed
   } rttk_cmd_type;

   // score of a slot after reset, saturating at zero
   function automatic logic [POINTS_W-1:0] reset_points(input int unsigned rank);
      logic [POINTS_W-1:0] drop;
      drop = POINTS_W'(rank * STEP_POINTS);
      if (rank >= 16 || drop >= TOP_POINTS) begin
         return '0;
      end
      return TOP_POINTS - drop;
   endfunction

endpackage

// File: hw/rtl/rttk_ram.sv
// generic single-port ram with registered read
module rttk_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/rttk_ctrl.sv
// sequencing state machine for the ranked top-k table
module rttk_ctrl
   import rttk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output rttk_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_STORE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_FETCH;
                  busy_ff  <= 1'b1;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               state_ff <= ST_STORE;
            end
            ST_STORE: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && start;
      cmd.fetch = (state_ff == ST_FETCH);
      cmd.eval  = (state_ff == ST_EVAL);
      cmd.store = (state_ff == ST_STORE);
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/rttk_dp.sv
// datapath: request capture, list row memory, compare and shift, result registers
module rttk_dp
   import rttk_pkg::*;
#(
   parameter int unsigned GROUPS  = GROUPS_DEF,
   parameter int unsigned CLASSES = CLASSES_DEF,
   parameter int unsigned RANKS   = RANKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rttk_cmd_type         cmd,
   input  logic                 req_kind,
   input  logic [GROUP_W-1:0]   req_list_group,
   input  logic [CLASS_W-1:0]   req_list_class,
   input  logic [RRANK_W-1:0]   req_read_rank,
   input  logic [POINTS_W-1:0]  req_new_points,
   input  logic [PAYLOAD_W-1:0] req_new_payload,
   output logic [PLACED_W-1:0]  rsp_placed_rank,
   output logic                 rsp_read_valid,
   output logic [POINTS_W-1:0]  rsp_read_points,
   output logic [PAYLOAD_W-1:0] rsp_read_payload
);

   localparam int unsigned LISTS  = GROUPS * CLASSES;
   localparam int unsigned LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int unsigned RANK_W = $clog2(RANKS);
   localparam int unsigned SUM_W  = GROUP_W + CLASS_W + 2;
   localparam int unsigned ROW_W  = RANKS * SLOT_W;
   localparam logic [PLACED_W-1:0] NOT_PLACED = PLACED_W'(RANKS);

   // captured request
   logic                 kind_ff;
   logic                 list_ok_ff;
   logic                 rank_ok_ff;
   logic [LIST_W-1:0]    list_ff;
   logic [RANK_W-1:0]    rank_ff;
   logic [POINTS_W-1:0]  points_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   // per-row written marks, unwritten rows read as reset contents
   logic [LISTS-1:0]     row_valid_ff;

   logic [ROW_W-1:0]     row_rdata;
   logic [ROW_W-1:0]     new_row_ff;
   logic [ROW_W-1:0]     new_row_in;
   logic                 place_ok_ff;

   logic [SUM_W-1:0]     list_sum;
   logic                 list_ok_in;
   logic                 rank_ok_in;

   logic [POINTS_W-1:0]  cur_pts  [RANKS];
   logic [PAYLOAD_W-1:0] cur_pay  [RANKS];
   logic [SLOT_W-1:0]    cur_slot [RANKS];
   logic [SLOT_W-1:0]    src_slot [RANKS];
   logic [RANKS-1:0]     ge;
   logic                 found;
   logic [RANK_W-1:0]    pos;
   logic                 insert_hit;
   logic                 read_hit;

   logic [PLACED_W-1:0]  placed_ff;
   logic                 rvalid_ff;
   logic [POINTS_W-1:0]  rpoints_ff;
   logic [PAYLOAD_W-1:0] rpayload_ff;

   always_comb begin
      list_sum   = SUM_W'(req_list_group) * SUM_W'(CLASSES) + SUM_W'(req_list_class);
      list_ok_in = (SUM_W'(req_list_group) < SUM_W'(GROUPS)) &&
                   (SUM_W'(req_list_class) < SUM_W'(CLASSES));
      rank_ok_in = (SUM_W'(req_read_rank) < SUM_W'(RANKS));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         list_ok_ff <= list_ok_in;
         rank_ok_ff <= rank_ok_in;
         list_ff    <= list_ok_in ? LIST_W'(list_sum) : '0;
         rank_ff    <= rank_ok_in ? RANK_W'(req_read_rank) : '0;
         points_ff  <= req_new_points;
         payload_ff <= req_new_payload;
      end
   end

   rttk_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LISTS)
   ) u_rows (
      .clock (clock),
      .we    (cmd.store && place_ok_ff),
      .re    (cmd.fetch),
      .addr  (list_ff),
      .wdata (new_row_ff),
      .rdata (row_rdata)
   );

   genvar g;
   for (g = 0; g < RANKS; g++) begin : g_slot
      assign cur_pts[g]  = row_valid_ff[list_ff] ? row_rdata[g*SLOT_W +: POINTS_W]
                                                 : reset_points(g);
      assign cur_pay[g]  = row_valid_ff[list_ff]
                         ? row_rdata[g*SLOT_W + POINTS_W +: PAYLOAD_W] : '0;
      assign cur_slot[g] = {cur_pay[g], cur_pts[g]};
      assign ge[g]       = (points_ff >= cur_pts[g]);
      if (g == 0) begin : g_first
         assign src_slot[g] = cur_slot[g];
      end else begin : g_rest
         assign src_slot[g] = cur_slot[g-1];
      end
      always_comb begin
         if (found && (RANK_W'(g) == pos)) begin
            new_row_in[g*SLOT_W +: SLOT_W] = {payload_ff, points_ff};
         end else if (found && (RANK_W'(g) > pos)) begin
            new_row_in[g*SLOT_W +: SLOT_W] = src_slot[g];
         end else begin
            new_row_in[g*SLOT_W +: SLOT_W] = cur_slot[g];
         end
      end
   end

   // first slot with score at or below the new one
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int r = RANKS - 1; r >= 0; r--) begin
         if (ge[r]) begin
            found = 1'b1;
            pos   = RANK_W'(r);
         end
      end
      insert_hit = (kind_ff == KIND_INSERT) && list_ok_ff && found;
      read_hit   = (kind_ff == KIND_READ) && list_ok_ff && rank_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         new_row_ff  <= new_row_in;
         place_ok_ff <= insert_hit;
         placed_ff   <= insert_hit ? PLACED_W'(pos) : NOT_PLACED;
         rvalid_ff   <= read_hit;
         rpoints_ff  <= read_hit ? cur_pts[rank_ff] : '0;
         rpayload_ff <= read_hit ? cur_pay[rank_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.store && place_ok_ff) begin
         row_valid_ff[list_ff] <= 1'b1;
      end
   end

   assign rsp_placed_rank  = placed_ff;
   assign rsp_read_valid   = rvalid_ff;
   assign rsp_read_points  = rpoints_ff;
   assign rsp_read_payload = rpayload_ff;

endmodule

// File: hw/rtl/ranked_top_k_table_insert_unit.sv
// top level of the ranked top-k table insert unit
//
//  channel   ports                                   handshake
//  request   req_kind, req_list_group, req_list_    start high while busy low
//            class, req_read_rank, req_new_points,
//            req_new_payload
//  response  rsp_placed_rank, rsp_read_valid,        rsp_strobe, one cycle per beat
//            rsp_read_points, rsp_read_payload
//
// every beat, insert or read, runs through the row memory while busy (fetch the
// list row, compare and shift, write back) and then raises the strobe, during
// which the next beat may already be taken
// one list is one memory row, so the single port of the row memory sets the pace
// reset is synchronous; per-row written marks clear at once and an unwritten
// row reads as its reset scores, so no clearing pass is needed
// the receiver cannot stall: each result is shown for exactly one cycle
module ranked_top_k_table_insert_unit
   import rttk_pkg::*;
#(
   parameter int unsigned GROUPS  = GROUPS_DEF,
   parameter int unsigned CLASSES = CLASSES_DEF,
   parameter int unsigned RANKS   = RANKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request beat
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [GROUP_W-1:0]   req_list_group,
   input  logic [CLASS_W-1:0]   req_list_class,
   input  logic [RRANK_W-1:0]   req_read_rank,
   input  logic [POINTS_W-1:0]  req_new_points,
   input  logic [PAYLOAD_W-1:0] req_new_payload,
   // response beat
   output logic                 rsp_strobe,
   output logic [PLACED_W-1:0]  rsp_placed_rank,
   output logic                 rsp_read_valid,
   output logic [POINTS_W-1:0]  rsp_read_points,
   output logic [PAYLOAD_W-1:0] rsp_read_payload
);

   // command group from the sequencer into the datapath
   rttk_cmd_type cmd;

   // sequencer: idle, fetch, evaluate, store
   rttk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // datapath: captures the beat, holds the list rows and builds the result
   rttk_dp #(
      .GROUPS  (GROUPS),
      .CLASSES (CLASSES),
      .RANKS   (RANKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_list_group   (req_list_group),
      .req_list_class   (req_list_class),
      .req_read_rank    (req_read_rank),
      .req_new_points   (req_new_points),
      .req_new_payload  (req_new_payload),
      .rsp_placed_rank  (rsp_placed_rank),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_points  (rsp_read_points),
      .rsp_read_payload (rsp_read_payload)
   );

endmodule

// File: test/tb_ranked_top_k_table_insert_unit.sv
// self-checking testbench for the ranked top-k table insert unit
module tb_ranked_top_k_table_insert_unit;
   import rttk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // code returned when an insert is not placed or is rejected
   localparam logic [PLACED_W-1:0] NOT_PLACED = PLACED_W'(RANKS_DEF);
   localparam logic [CLASS_W-1:0] DIRECTED_CLASS = CLASS_W'(2);
   localparam int unsigned PHASE_BEATS = 167;
   localparam int unsigned MAX_REPORTS = 10;

   // one predicted response beat
   typedef struct {
      logic [PLACED_W-1:0]  placed;
      logic                 valid;
      logic [POINTS_W-1:0]  points;
      logic [PAYLOAD_W-1:0] payload;
   } rsp_beat_type;

   // shadow copy of every ranked list plus the queue of responses still owed
   class rank_scoreboard;
      logic [POINTS_W-1:0]  list_score [GROUPS_DEF][CLASSES_DEF][RANKS_DEF];
      logic [PAYLOAD_W-1:0] list_data  [GROUPS_DEF][CLASSES_DEF][RANKS_DEF];
      rsp_beat_type         owed_rsp [$];
      int unsigned          mismatches;

      function new();
         int unsigned drop;
         mismatches = 0;
         for (int g = 0; g < GROUPS_DEF; g++) begin
            for (int c = 0; c < CLASSES_DEF; c++) begin
               for (int r = 0; r < RANKS_DEF; r++) begin
                  drop = r * STEP_POINTS;
                  list_score[g][c][r] = (drop >= TOP_POINTS) ? '0 : TOP_POINTS - drop;
                  list_data[g][c][r]  = '0;
               end
            end
         end
      endfunction

      function logic [POINTS_W-1:0] slot_score(int unsigned g, int unsigned c,
                                               int unsigned r);
         return list_score[g][c][r];
      endfunction

      function int unsigned pending();
         return owed_rsp.size();
      endfunction

      // update the shadow lists for an accepted request and queue its response
      function void note_request(logic kind, logic [GROUP_W-1:0] grp,
                                 logic [CLASS_W-1:0] cls, logic [RRANK_W-1:0] rank,
                                 logic [POINTS_W-1:0] pts, logic [PAYLOAD_W-1:0] pay);
         rsp_beat_type want;
         bit           list_ok;
         want    = '{NOT_PLACED, 1'b0, '0, '0};
         list_ok = (grp < GROUPS_DEF) && (cls < CLASSES_DEF);
         if (kind == KIND_INSERT) begin
            if (list_ok) begin
               for (int r = 0; r < RANKS_DEF; r++) begin
                  if (pts >= list_score[grp][cls][r]) begin
                     for (int n = RANKS_DEF - 1; n > r; n--) begin
                        list_score[grp][cls][n] = list_score[grp][cls][n-1];
                        list_data[grp][cls][n]  = list_data[grp][cls][n-1];
                     end
                     list_score[grp][cls][r] = pts;
                     list_data[grp][cls][r]  = pay;
                     want.placed = PLACED_W'(r);
                     break;
                  end
               end
            end
         end else if (list_ok && rank < RANKS_DEF) begin
            want.valid   = 1'b1;
            want.points  = list_score[grp][cls][rank];
            want.payload = list_data[grp][cls][rank];
         end
         owed_rsp.push_back(want);
      endfunction

      // compare one response beat with the oldest owed one
      function void check_result(logic [PLACED_W-1:0] placed, logic valid,
                                 logic [POINTS_W-1:0] points,
                                 logic [PAYLOAD_W-1:0] payload);
         rsp_beat_type want;
         if (owed_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response beat: placed %0d valid %0d points %0h %s %0h",
                        placed, valid, points, "payload", payload);
            return;
         end
         want = owed_rsp.pop_front();
         if (placed !== want.placed || valid !== want.valid ||
             points !== want.points || payload !== want.payload) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("response mismatch: want placed %0d valid %0d points %0h payload %0h",
                        want.placed, want.valid, want.points, want.payload);
               $display("                    got  placed %0d valid %0d points %0h payload %0h",
                        placed, valid, points, payload);
            end
         end
      endfunction

      // anything still owed at the end is a failure
      function void close();
         if (owed_rsp.size() != 0) begin
            mismatches += owed_rsp.size();
            $display("%0d response beats never arrived", owed_rsp.size());
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic [GROUP_W-1:0]   req_list_group;
   logic [CLASS_W-1:0]   req_list_class;
   logic [RRANK_W-1:0]   req_read_rank;
   logic [POINTS_W-1:0]  req_new_points;
   logic [PAYLOAD_W-1:0] req_new_payload;
   logic                 rsp_strobe;
   logic [PLACED_W-1:0]  rsp_placed_rank;
   logic                 rsp_read_valid;
   logic [POINTS_W-1:0]  rsp_read_points;
   logic [PAYLOAD_W-1:0] rsp_read_payload;

   rank_scoreboard sb = new();

   ranked_top_k_table_insert_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_list_group   (req_list_group),
      .req_list_class   (req_list_class),
      .req_read_rank    (req_read_rank),
      .req_new_points   (req_new_points),
      .req_new_payload  (req_new_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_placed_rank  (rsp_placed_rank),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_points  (rsp_read_points),
      .rsp_read_payload (rsp_read_payload)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // the receiver cannot stall, so every strobe beat is checked as it appears
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_placed_rank, rsp_read_valid, rsp_read_points, rsp_read_payload);
   end

   // present one request beat from a falling edge and hold it until taken
   task automatic send_request(logic kind, logic [GROUP_W-1:0] grp, logic [CLASS_W-1:0] cls,
                               logic [RRANK_W-1:0] rank, logic [POINTS_W-1:0] pts,
                               logic [PAYLOAD_W-1:0] pay);
      @(negedge clock);
      start           <= 1'b1;
      req_kind        <= kind;
      req_list_group  <= grp;
      req_list_class  <= cls;
      req_read_rank   <= rank;
      req_new_points  <= pts;
      req_new_payload <= pay;
      // beat is taken at the first rising edge that sees busy low
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      sb.note_request(kind, grp, cls, rank, pts, pay);
   endtask

   // sender gap, with the points and payload fields scrambled so stale data is never relied on
   task automatic sender_gap(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start           <= 1'b0;
         req_new_points  <= $urandom;
         req_new_payload <= {$urandom, $urandom};
      end
   endtask

   // hold off the sender until every owed response has come back
   task automatic drain_responses();
      sender_gap(1);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // one random beat; most traffic hits a few lists so they fill and churn
   task automatic random_beat(int unsigned idle_pct);
      logic                 kind;
      logic [GROUP_W-1:0]   grp;
      logic [CLASS_W-1:0]   cls;
      logic [RRANK_W-1:0]   rank;
      logic [POINTS_W-1:0]  pts;
      logic [PAYLOAD_W-1:0] pay;
      int unsigned          pick;
      if ($urandom_range(0, 99) < idle_pct)
         sender_gap($urandom_range(1, 6));
      kind = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_READ;
      grp  = ($urandom_range(0, 99) < 70) ? GROUP_W'($urandom_range(0, 2)) : GROUP_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60)
         cls = CLASS_W'($urandom_range(0, 1));
      else if (pick < 90)
         cls = CLASS_W'($urandom_range(0, CLASSES_DEF - 1));
      else
         cls = CLASS_W'($urandom_range(CLASSES_DEF, 7));
      rank = ($urandom_range(0, 99) < 85) ? RRANK_W'($urandom_range(0, RANKS_DEF - 1))
                                          : RRANK_W'($urandom);
      pay  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 35 && cls < CLASSES_DEF) begin
         // tie with, or land just either side of, a score already in the list
         pts = sb.slot_score(grp, cls, $urandom_range(0, RANKS_DEF - 1));
         case ($urandom_range(0, 2))
            0: pts = pts + 1;
            1: if (pts != 0) pts = pts - 1;
            default: ;
         endcase
      end else if (pick < 75) begin
         pts = $urandom_range(0, 130000);
      end else if (pick < 80) begin
         pts = ($urandom_range(0, 1) == 0) ? '0 : '1;
      end else begin
         pts = $urandom;
      end
      send_request(kind, grp, cls, rank, pts, pay);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = KIND_INSERT;
      req_list_group  = '0;
      req_list_class  = '0;
      req_read_rank   = '0;
      req_new_points  = '0;
      req_new_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset contents, including the ranks past the end of a list
      for (int r = 0; r < 8; r++)
         send_request(KIND_READ, 0, 0, RRANK_W'(r), '1, '1);
      send_request(KIND_READ, 15, 4, 4, '0, '0);
      // class out of range on a read
      send_request(KIND_READ, 15, 5, 0, '0, '0);
      send_request(KIND_READ, 15, 7, 7, '1, '1);

      // score below every slot leaves the list alone
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 7, '0, 64'h0123_4567_89ab_cdef);
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 0, 32'd19999, 64'h1);
      // ties place the newcomer ahead, at the bottom and at the top
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 0, 32'd20000, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 0, 32'd100000, 64'h5555_5555_5555_5555);
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 0, '1, '1);
      send_request(KIND_INSERT, 3, DIRECTED_CLASS, 0, 32'd60000, 64'h8000_0000_0000_0001);
      // class out of range on an insert
      send_request(KIND_INSERT, 3, 5, 0, '1, '1);
      send_request(KIND_INSERT, 15, 7, 7, '1, '1);
      for (int r = 0; r < RANKS_DEF; r++)
         send_request(KIND_READ, 3, DIRECTED_CLASS, RRANK_W'(r), '0, '0);

      drain_responses();

      // random part in three idling phases: light gaps, heavy gaps, back to back
      for (int b = 0; b < PHASE_BEATS; b++) begin
         random_beat(15);
         if (b == PHASE_BEATS / 2)
            drain_responses();
      end
      for (int b = 0; b < PHASE_BEATS; b++)
         random_beat(86);
      for (int b = 0; b < PHASE_BEATS; b++)
         random_beat(0);

      sender_gap(1);
      while (sb.pending() != 0)
         @(posedge clock);
      // keep watching a little longer to catch any stray beat
      repeat (8) @(posedge clock);
      sb.close();
      if (sb.mismatches == 0)
         $display("tb_ranked_top_k_table_insert_unit passed");
      else
         $display("tb_ranked_top_k_table_insert_unit failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #200000;
      $display("tb_ranked_top_k_table_insert_unit failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/rttk_pkg.sv
hw/rtl/rttk_ram.sv
hw/rtl/rttk_ctrl.sv
hw/rtl/rttk_dp.sv
hw/rtl/ranked_top_k_table_insert_unit.sv
test/tb_ranked_top_k_table_insert_unit.sv
